[rtl/core/imudr_pkg.sv]
package imudr_pkg;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 24;

  localparam logic [CFG_IDX_W-1:0] REG_TIME_STEP        = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GRAVITY          = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ACCEL_SMOOTHING  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_VERTICAL_BLEND   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_HORIZONTAL_BLEND = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_FLOW_TO_METERS   = 3'd5;

  localparam logic [15:0] RST_TIME_STEP        = 16'd655;
  localparam logic [15:0] RST_GRAVITY          = 16'd2511;
  localparam logic [15:0] RST_ACCEL_SMOOTHING  = 16'd58982;
  localparam logic [15:0] RST_VERTICAL_BLEND   = 16'd64225;
  localparam logic [15:0] RST_HORIZONTAL_BLEND = 16'd58982;
  localparam logic [23:0] RST_FLOW_TO_METERS   = 24'd65536;

  localparam int unsigned CORDIC_ITERS = 16;
  localparam logic signed [34:0] CORDIC_GAIN = 35'sd652032874;
  localparam logic signed [34:0] PI_Q30      = 35'sd3373259426;
  localparam logic signed [34:0] HALF_PI_Q30 = 35'sd1686629713;

  // Magnitude width of the largest quotient numerator.
  localparam int unsigned DIV_W = 56;

  function automatic logic signed [34:0] atan_q30(input logic [3:0] i);
    logic signed [34:0] a;
    case (i)
      4'd0:    a = 35'sd843314857;
      4'd1:    a = 35'sd497837829;
      4'd2:    a = 35'sd263043837;
      4'd3:    a = 35'sd133525159;
      4'd4:    a = 35'sd67021687;
      4'd5:    a = 35'sd33543516;
      4'd6:    a = 35'sd16775851;
      4'd7:    a = 35'sd8388437;
      4'd8:    a = 35'sd4194283;
      4'd9:    a = 35'sd2097149;
      4'd10:   a = 35'sd1048576;
      4'd11:   a = 35'sd524288;
      4'd12:   a = 35'sd262144;
      4'd13:   a = 35'sd131072;
      4'd14:   a = 35'sd65536;
      default: a = 35'sd32768;
    endcase
    return a;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
    logic signed [31:0] r;
    if (v > 66'sd2147483647) r = 32'sh7FFFFFFF;
    else if (v < -66'sd2147483648) r = 32'sh80000000;
    else r = v[31:0];
    return r;
  endfunction

  // Round to nearest, ties toward plus infinity, then shift right.
  function automatic logic signed [65:0] rnd_sh(input logic signed [65:0] v,
                                                input int unsigned s);
    logic signed [65:0] r;
    r = (v + (66'sd1 <<< (s - 1))) >>> s;
    return r;
  endfunction

  function automatic logic signed [15:0] clamp_q14(input logic signed [34:0] v);
    logic signed [34:0] r;
    logic signed [15:0] c;
    r = (v + 35'sd32768) >>> 16;
    if (r > 35'sd16384) c = 16'sd16384;
    else if (r < -35'sd16384) c = -16'sd16384;
    else c = r[15:0];
    return c;
  endfunction

endpackage

[rtl/core/imudr_in_if.sv]
interface imudr_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] accel_x;
  logic signed [15:0] accel_y;
  logic signed [15:0] accel_z;
  logic signed [15:0] pitch_angle;
  logic signed [15:0] roll_angle;
  logic signed [31:0] lidar_height;
  logic signed [15:0] flow_dx;
  logic signed [15:0] flow_dy;

  modport source(output valid, accel_x, accel_y, accel_z, pitch_angle, roll_angle,
                 lidar_height, flow_dx, flow_dy, input ready);
  modport sink(input valid, accel_x, accel_y, accel_z, pitch_angle, roll_angle,
               lidar_height, flow_dx, flow_dy, output ready);
endinterface

[rtl/core/imudr_out_if.sv]
interface imudr_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic        [30:0] pos_z;
  logic signed [31:0] vel_x;
  logic signed [31:0] vel_y;
  logic signed [31:0] vel_z;

  modport source(output valid, pos_x, pos_y, pos_z, vel_x, vel_y, vel_z, input ready);
  modport sink(input valid, pos_x, pos_y, pos_z, vel_x, vel_y, vel_z, output ready);
endinterface

[rtl/core/imudr_cfg_if.sv]
interface imudr_cfg_if;
  import imudr_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  idx;
  logic [CFG_DATA_W-1:0] data;

  modport source(output valid, idx, data, input ready);
  modport sink(input valid, idx, data, output ready);
endinterface

[rtl/core/imu_flow_lidar_dead_reckoning_unit.sv]
// Channel   Dir  Beat contents
// in_ch     in   accel_x/y/z, pitch_angle, roll_angle, lidar_height, flow_dx/dy
// out_ch    out  pos_x, pos_y, pos_z, vel_x, vel_y, vel_z
// cfg_ch    in   idx (register number), data (write value)
//
// A sample occupies the unit from its accepting edge to the next possible one: two
// CORDIC passes, the multiply and update steps on the one shared multiplier, and
// three 56-step restoring divisions by dt. The first sample skips the filter; with
// dt at zero the divisions are skipped. Reset is synchronous, clears the filter,
// velocity, position, lidar history and output valid state and loads the default
// registers. A new beat is accepted only while idle; a finished result waits in the
// output register and stalls the sequencer only if the previous one is untaken.
module imu_flow_lidar_dead_reckoning_unit (
  input  logic               clk,
  input  logic               rst_n,
  imudr_in_if.sink           in_ch,
  imudr_out_if.source        out_ch,
  imudr_cfg_if.sink          cfg_ch
);
  import imudr_pkg::*;

  localparam logic [4:0] S_IDLE  = 5'd0;
  localparam logic [4:0] S_CINIT = 5'd1;
  localparam logic [4:0] S_CORD  = 5'd2;
  localparam logic [4:0] S_CFIN  = 5'd3;
  localparam logic [4:0] S_G0    = 5'd4;
  localparam logic [4:0] S_G1    = 5'd5;
  localparam logic [4:0] S_G2    = 5'd6;
  localparam logic [4:0] S_G3    = 5'd7;
  localparam logic [4:0] S_G4    = 5'd8;
  localparam logic [4:0] S_G5    = 5'd9;
  localparam logic [4:0] S_FA    = 5'd10;
  localparam logic [4:0] S_FB    = 5'd11;
  localparam logic [4:0] S_FC    = 5'd12;
  localparam logic [4:0] S_V0    = 5'd13;
  localparam logic [4:0] S_V1    = 5'd14;
  localparam logic [4:0] S_V2    = 5'd15;
  localparam logic [4:0] S_DIV   = 5'd16;
  localparam logic [4:0] S_DEND  = 5'd17;
  localparam logic [4:0] S_B0    = 5'd18;
  localparam logic [4:0] S_B1    = 5'd19;
  localparam logic [4:0] S_B2    = 5'd20;
  localparam logic [4:0] S_P0    = 5'd21;
  localparam logic [4:0] S_P1    = 5'd22;
  localparam logic [4:0] S_DONE  = 5'd23;

  logic [4:0] state_r;

  logic [15:0] dt_r, g_r, as_r, vb_r, hb_r;
  logic [23:0] ftm_r;

  logic signed [15:0] ax_r, ay_r, az_r, pitch_r, roll_r, fdx_r, fdy_r;
  logic signed [31:0] lidar_r;

  logic signed [31:0] fa_r  [0:2];
  logic signed [31:0] vel_r [0:2];
  logic signed [31:0] pos_r [0:2];
  logic signed [31:0] lin_r [0:2];
  logic signed [31:0] last_r;
  logic               first_r;

  logic signed [34:0] cx_r, cy_r, cz_r;
  logic [3:0]         it_r;
  logic               flip_r, sel_r;
  logic signed [15:0] sp_r, cp_r, sr_r, cr_r;

  logic [1:0]         k_r;
  logic signed [65:0] prod_r, acc_r;
  logic signed [31:0] vimu_r, vsrc_r;

  logic [DIV_W-1:0]   dn_r;
  logic [15:0]        rem_r;
  logic               dneg_r;
  logic [5:0]         dcnt_r;

  logic signed [31:0] pos_x_r, pos_y_r, vel_x_r, vel_y_r, vel_z_r;
  logic [30:0]        pos_z_r;
  logic               out_valid_r;

  // Shared multiplier operands.
  logic signed [32:0] mul_a, mul_b;
  logic [15:0]        w_sel;
  logic [16:0]        w_inv;
  logic signed [15:0] flow_k;

  // CORDIC and divider helpers.
  logic signed [15:0] ang;
  logic signed [34:0] z0;
  logic signed [34:0] xs, ys;
  logic signed [15:0] c_q, s_q;
  logic signed [32:0] ldiff;
  logic signed [65:0] num_sel, mag_w;
  logic [16:0]        dtry;
  logic               dbit;
  logic signed [65:0] qsgn;
  logic signed [31:0] lin_new, blend_new, pos_new;

  assign w_sel  = (k_r == 2'd2) ? vb_r : hb_r;
  assign flow_k = (k_r == 2'd0) ? fdx_r : fdy_r;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    w_inv = 17'h10000 - {1'b0, w_sel};
    case (state_r)
      S_G0: begin mul_a = $signed({17'b0, g_r}); mul_b = 33'(sp_r); end
      S_G1: begin mul_a = $signed({17'b0, g_r}); mul_b = 33'(sr_r); end
      S_G2: begin mul_a = prod_r[32:0]; mul_b = 33'(cp_r); end
      S_G3: begin mul_a = $signed({17'b0, g_r}); mul_b = 33'(cr_r); end
      S_G4: begin mul_a = prod_r[32:0]; mul_b = 33'(cp_r); end
      S_FA: begin mul_a = $signed({17'b0, as_r}); mul_b = 33'(fa_r[k_r]); end
      S_FB: begin
        mul_a = $signed({16'b0, 17'h10000 - {1'b0, as_r}});
        mul_b = 33'(lin_r[k_r]);
      end
      S_V0: begin mul_a = 33'(fa_r[k_r]); mul_b = $signed({17'b0, dt_r}); end
      S_V1: begin mul_a = 33'(flow_k); mul_b = $signed({9'b0, ftm_r}); end
      S_B0: begin mul_a = $signed({17'b0, w_sel}); mul_b = 33'(vimu_r); end
      S_B1: begin mul_a = $signed({16'b0, w_inv}); mul_b = 33'(vsrc_r); end
      S_P0: begin mul_a = 33'(vel_r[k_r]); mul_b = $signed({17'b0, dt_r}); end
      default: begin mul_a = '0; mul_b = '0; end
    endcase
  end

  always_comb begin
    ang = sel_r ? roll_r : pitch_r;
    z0  = $signed({{2{ang[15]}}, ang, 17'b0});
    xs  = cx_r >>> it_r;
    ys  = cy_r >>> it_r;
    c_q = clamp_q14(cx_r);
    s_q = clamp_q14(cy_r);
    if (flip_r) begin
      c_q = -c_q;
      s_q = -s_q;
    end
    ldiff   = 33'(lidar_r) - 33'(last_r);
    num_sel = (state_r == S_V1) ? ($signed({{17{ldiff[32]}}, ldiff, 16'b0}))
                                : (prod_r <<< 16);
    mag_w   = num_sel[65] ? -num_sel : num_sel;
    dtry    = {rem_r, dn_r[DIV_W-1]};
    dbit    = (dtry >= {1'b0, dt_r});
    qsgn    = dneg_r ? -$signed({10'b0, dn_r}) : $signed({10'b0, dn_r});
    lin_new = sat32((66'(az_r) <<< 8) - rnd_sh(prod_r, 20));
    blend_new = sat32(rnd_sh(acc_r + prod_r, 16));
    pos_new = sat32(66'(pos_r[k_r]) + 66'(sat32(rnd_sh(prod_r, 16))));
  end

  assign in_ch.ready  = (state_r == S_IDLE);
  assign cfg_ch.ready = 1'b1;
  assign out_ch.valid = out_valid_r;
  assign out_ch.pos_x = pos_x_r;
  assign out_ch.pos_y = pos_y_r;
  assign out_ch.pos_z = pos_z_r;
  assign out_ch.vel_x = vel_x_r;
  assign out_ch.vel_y = vel_y_r;
  assign out_ch.vel_z = vel_z_r;

  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      first_r     <= 1'b1;
      last_r      <= '0;
      for (int i = 0; i < 3; i++) begin
        fa_r[i]  <= '0;
        vel_r[i] <= '0;
        pos_r[i] <= '0;
      end
      dt_r  <= RST_TIME_STEP;
      g_r   <= RST_GRAVITY;
      as_r  <= RST_ACCEL_SMOOTHING;
      vb_r  <= RST_VERTICAL_BLEND;
      hb_r  <= RST_HORIZONTAL_BLEND;
      ftm_r <= RST_FLOW_TO_METERS;
      sel_r <= 1'b0;
      k_r   <= '0;
    end else begin
      if (cfg_ch.valid) begin
        case (cfg_ch.idx)
          REG_TIME_STEP:        dt_r  <= cfg_ch.data[15:0];
          REG_GRAVITY:          g_r   <= cfg_ch.data[15:0];
          REG_ACCEL_SMOOTHING:  as_r  <= cfg_ch.data[15:0];
          REG_VERTICAL_BLEND:   vb_r  <= cfg_ch.data[15:0];
          REG_HORIZONTAL_BLEND: hb_r  <= cfg_ch.data[15:0];
          REG_FLOW_TO_METERS:   ftm_r <= cfg_ch.data;
          default: ;
        endcase
      end

      if (out_valid_r && out_ch.ready && state_r != S_DONE) out_valid_r <= 1'b0;

      case (state_r)
        S_IDLE: begin
          if (in_ch.valid) begin
            ax_r    <= in_ch.accel_x;
            ay_r    <= in_ch.accel_y;
            az_r    <= in_ch.accel_z;
            pitch_r <= in_ch.pitch_angle;
            roll_r  <= in_ch.roll_angle;
            lidar_r <= in_ch.lidar_height;
            fdx_r   <= in_ch.flow_dx;
            fdy_r   <= in_ch.flow_dy;
            sel_r   <= 1'b0;
            state_r <= S_CINIT;
          end
        end
        S_CINIT: begin
          cx_r <= CORDIC_GAIN;
          cy_r <= '0;
          it_r <= '0;
          if (z0 > HALF_PI_Q30) begin
            cz_r <= z0 - PI_Q30; flip_r <= 1'b1;
          end else if (z0 < -HALF_PI_Q30) begin
            cz_r <= z0 + PI_Q30; flip_r <= 1'b1;
          end else begin
            cz_r <= z0; flip_r <= 1'b0;
          end
          state_r <= S_CORD;
        end
        S_CORD: begin
          if (!cz_r[34]) begin
            cx_r <= cx_r - ys; cy_r <= cy_r + xs; cz_r <= cz_r - atan_q30(it_r);
          end else begin
            cx_r <= cx_r + ys; cy_r <= cy_r - xs; cz_r <= cz_r + atan_q30(it_r);
          end
          it_r <= it_r + 4'd1;
          if (it_r == 4'(CORDIC_ITERS - 1)) state_r <= S_CFIN;
        end
        S_CFIN: begin
          if (!sel_r) begin
            sp_r <= s_q; cp_r <= c_q; sel_r <= 1'b1; state_r <= S_CINIT;
          end else begin
            sr_r <= s_q; cr_r <= c_q; state_r <= S_G0;
          end
        end
        S_G0: state_r <= S_G1;
        S_G1: begin
          lin_r[0] <= sat32((66'(ax_r) <<< 8) - rnd_sh(prod_r, 6));
          state_r  <= S_G2;
        end
        S_G2: state_r <= S_G3;
        S_G3: begin
          lin_r[1] <= sat32((66'(ay_r) <<< 8) - rnd_sh(-prod_r, 20));
          state_r  <= S_G4;
        end
        S_G4: state_r <= S_G5;
        S_G5: begin
          lin_r[2] <= lin_new;
          if (first_r) begin
            // The first sample seeds the filter and the lidar history.
            fa_r[0] <= lin_r[0];
            fa_r[1] <= lin_r[1];
            fa_r[2] <= lin_new;
            last_r  <= lidar_r;
            first_r <= 1'b0;
            k_r     <= 2'd2;
            state_r <= S_V0;
          end else begin
            k_r     <= 2'd0;
            state_r <= S_FA;
          end
        end
        S_FA: state_r <= S_FB;
        S_FB: begin
          acc_r   <= prod_r;
          state_r <= S_FC;
        end
        S_FC: begin
          fa_r[k_r] <= blend_new;
          if (k_r == 2'd2) begin
            state_r <= S_V0;
          end else begin
            k_r     <= k_r + 2'd1;
            state_r <= S_FA;
          end
        end
        S_V0: state_r <= S_V1;
        S_V1, S_V2: begin
          if (state_r == S_V1) begin
            vimu_r <= sat32(66'(vel_r[k_r]) + 66'(sat32(rnd_sh(prod_r, 16))));
          end
          if (state_r == S_V1 && k_r != 2'd2) begin
            state_r <= S_V2;
          end else begin
            if (state_r == S_V1) last_r <= lidar_r;
            dneg_r <= num_sel[65];
            dn_r   <= mag_w[DIV_W-1:0];
            rem_r  <= '0;
            dcnt_r <= '0;
            if (dt_r == 16'd0) begin
              if (num_sel == 66'sd0) vsrc_r <= '0;
              else if (num_sel[65]) vsrc_r <= 32'sh80000000;
              else vsrc_r <= 32'sh7FFFFFFF;
              state_r <= S_B0;
            end else begin
              state_r <= S_DIV;
            end
          end
        end
        S_DIV: begin
          rem_r  <= dbit ? 16'(dtry - {1'b0, dt_r}) : dtry[15:0];
          dn_r   <= {dn_r[DIV_W-2:0], dbit};
          dcnt_r <= dcnt_r + 6'd1;
          if (dcnt_r == 6'(DIV_W - 1)) state_r <= S_DEND;
        end
        S_DEND: begin
          vsrc_r  <= sat32(qsgn);
          state_r <= S_B0;
        end
        S_B0: state_r <= S_B1;
        S_B1: begin
          acc_r   <= prod_r;
          state_r <= S_B2;
        end
        S_B2: begin
          vel_r[k_r] <= blend_new;
          state_r    <= S_P0;
        end
        S_P0: state_r <= S_P1;
        S_P1: begin
          if (k_r == 2'd2 && pos_new[31]) pos_r[k_r] <= '0;
          else pos_r[k_r] <= pos_new;
          case (k_r)
            2'd2:    begin k_r <= 2'd0; state_r <= S_V0; end
            2'd0:    begin k_r <= 2'd1; state_r <= S_V0; end
            default: state_r <= S_DONE;
          endcase
        end
        S_DONE: begin
          if (!out_valid_r || out_ch.ready) begin
            pos_x_r     <= pos_r[0];
            pos_y_r     <= pos_r[1];
            pos_z_r     <= pos_r[2][30:0];
            vel_x_r     <= vel_r[0];
            vel_y_r     <= vel_r[1];
            vel_z_r     <= vel_r[2];
            out_valid_r <= 1'b1;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

[bench/imudr_tb_pkg.sv]
package imudr_tb_pkg;
  import imudr_pkg::*;

  typedef struct packed {
    logic signed [15:0] accel_x;
    logic signed [15:0] accel_y;
    logic signed [15:0] accel_z;
    logic signed [15:0] pitch_angle;
    logic signed [15:0] roll_angle;
    logic signed [31:0] lidar_height;
    logic signed [15:0] flow_dx;
    logic signed [15:0] flow_dy;
  } imu_sample_t;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic        [30:0] pos_z;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic signed [31:0] vel_z;
  } nav_state_t;

  typedef struct packed {
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0] data;
  } reg_write_t;
endpackage

[bench/tb_imu_flow_lidar_dead_reckoning_unit.sv]
module tb_imu_flow_lidar_dead_reckoning_unit;
  import imudr_pkg::*;
  import imudr_tb_pkg::*;

  localparam int IDLE_LIMIT = 20000;
  localparam int SETTLE_CYCLES = 400;

  logic clk;
  logic rst_n;

  imudr_in_if  in_ch();
  imudr_out_if out_ch();
  imudr_cfg_if cfg_ch();

  imu_flow_lidar_dead_reckoning_unit dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch), .cfg_ch(cfg_ch)
  );

  // Model copy of the registers and filter state.
  logic [15:0] m_dt, m_grav, m_smooth, m_vblend, m_hblend;
  logic [23:0] m_flow_scale;
  longint m_facc[3], m_vel[3], m_pos[3], m_last_lidar;
  bit m_first;

  imu_sample_t sample_q[$];
  nav_state_t  nav_expect_q[$];

  int errors = 0;
  int samples_sent = 0;
  int results_seen = 0;
  int regs_written = 0;
  int idle_cycles = 0;
  bit timed_out = 0;
  bit in_fire = 0;

  always begin
    clk = 1'b1; #4;
    clk = 1'b0; #4;
  end

  function automatic longint asr_n(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint round_sh(longint v, int s);
    return (v + (longint'(1) <<< (s - 1))) >>> s;
  endfunction

  function automatic longint clip32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint clip_q14(longint v);
    if (v > 16384) return 16384;
    if (v < -16384) return -16384;
    return v;
  endfunction

  function automatic longint arctan_step(int i);
    longint tbl[16] = '{843314857, 497837829, 263043837, 133525159, 67021687, 33543516,
                        16775851, 8388437, 4194283, 2097149, 1048576, 524288, 262144,
                        131072, 65536, 32768};
    return tbl[i];
  endfunction

  task automatic rotate_angle(input logic signed [15:0] ang, output longint s,
                              output longint c);
    longint z, x, y, xs, ys;
    bit flip;
    z = longint'(ang) * 131072;
    x = 652032874;
    y = 0;
    flip = 0;
    if (z > 64'sd1686629713) begin
      z -= 64'sd3373259426; flip = 1;
    end else if (z < -64'sd1686629713) begin
      z += 64'sd3373259426; flip = 1;
    end
    for (int i = 0; i < 16; i++) begin
      xs = asr_n(x, i);
      ys = asr_n(y, i);
      if (z >= 0) begin
        x -= ys; y += xs; z -= arctan_step(i);
      end else begin
        x += ys; y -= xs; z += arctan_step(i);
      end
    end
    c = clip_q14(round_sh(x, 16));
    s = clip_q14(round_sh(y, 16));
    if (flip) begin
      c = -c; s = -s;
    end
  endtask

  function automatic longint mix(logic [15:0] w, longint a, longint b);
    longint wl;
    wl = longint'(w);
    return clip32(round_sh(wl * a + (65536 - wl) * b, 16));
  endfunction

  function automatic longint scale_by_dt(longint v);
    return clip32(round_sh(v * longint'(m_dt), 16));
  endfunction

  function automatic longint rate_over_dt(longint num);
    if (m_dt == 0) return num > 0 ? 64'sd2147483647 : (num < 0 ? -64'sd2147483648 : 0);
    return num / longint'(m_dt);
  endfunction

  function automatic void model_reset();
    m_dt = RST_TIME_STEP; m_grav = RST_GRAVITY; m_smooth = RST_ACCEL_SMOOTHING;
    m_vblend = RST_VERTICAL_BLEND; m_hblend = RST_HORIZONTAL_BLEND;
    m_flow_scale = RST_FLOW_TO_METERS;
    for (int i = 0; i < 3; i++) begin
      m_facc[i] = 0; m_vel[i] = 0; m_pos[i] = 0;
    end
    m_last_lidar = 0;
    m_first = 1;
  endfunction

  function automatic void model_write(reg_write_t w);
    case (w.idx)
      REG_TIME_STEP:        m_dt = w.data[15:0];
      REG_GRAVITY:          m_grav = w.data[15:0];
      REG_ACCEL_SMOOTHING:  m_smooth = w.data[15:0];
      REG_VERTICAL_BLEND:   m_vblend = w.data[15:0];
      REG_HORIZONTAL_BLEND: m_hblend = w.data[15:0];
      REG_FLOW_TO_METERS:   m_flow_scale = w.data;
      default: ;
    endcase
  endfunction

  task automatic dead_reckon(input imu_sample_t smp, output nav_state_t res);
    longint acc[3], grav_body[3], lin[3], g, sp, cp, sr, cr, lidar, v_imu, v_src, fl;
    logic signed [15:0] flows[2];
    g = longint'(m_grav);
    acc[0] = longint'(smp.accel_x) * 256;
    acc[1] = longint'(smp.accel_y) * 256;
    acc[2] = longint'(smp.accel_z) * 256;
    rotate_angle(smp.pitch_angle, sp, cp);
    rotate_angle(smp.roll_angle, sr, cr);
    lidar = longint'(smp.lidar_height);
    flows[0] = smp.flow_dx;
    flows[1] = smp.flow_dy;
    grav_body[0] = round_sh(g * sp, 6);
    grav_body[1] = round_sh(-(g * sr * cp), 20);
    grav_body[2] = round_sh(g * cr * cp, 20);
    for (int i = 0; i < 3; i++) lin[i] = clip32(acc[i] - grav_body[i]);
    if (m_first) begin
      for (int i = 0; i < 3; i++) m_facc[i] = lin[i];
      m_last_lidar = lidar;
      m_first = 0;
    end else begin
      for (int i = 0; i < 3; i++) m_facc[i] = mix(m_smooth, m_facc[i], lin[i]);
    end
    v_imu = clip32(m_vel[2] + scale_by_dt(m_facc[2]));
    v_src = clip32(rate_over_dt((lidar - m_last_lidar) * 65536));
    m_last_lidar = lidar;
    m_vel[2] = mix(m_vblend, v_imu, v_src);
    m_pos[2] = clip32(m_pos[2] + scale_by_dt(m_vel[2]));
    if (m_pos[2] < 0) m_pos[2] = 0;
    for (int i = 0; i < 2; i++) begin
      fl = longint'(flows[i]);
      v_imu = clip32(m_vel[i] + scale_by_dt(m_facc[i]));
      v_src = clip32(rate_over_dt(fl * longint'(m_flow_scale) * 65536));
      m_vel[i] = mix(m_hblend, v_imu, v_src);
      m_pos[i] = clip32(m_pos[i] + scale_by_dt(m_vel[i]));
    end
    res.pos_x = m_pos[0][31:0];
    res.pos_y = m_pos[1][31:0];
    res.pos_z = m_pos[2][30:0];
    res.vel_x = m_vel[0][31:0];
    res.vel_y = m_vel[1][31:0];
    res.vel_z = m_vel[2][31:0];
  endtask

  // Remembers whether the input beat was taken at the last rising edge.
  always @(posedge clk) begin
    in_fire <= rst_n && in_ch.valid && in_ch.ready;
  end

  // Sender: bursts of beats separated by random gaps.
  int burst_left = 0;
  int gap_left = 0;
  always @(negedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_fire) begin
        void'(sample_q.pop_front());
      end
      if (in_ch.valid && !in_fire) begin
        // Hold the current beat.
      end else if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        in_ch.valid <= 1'b0;
      end else if (sample_q.size() > 0) begin
        imu_sample_t nx;
        nx = sample_q[0];
        in_ch.valid <= 1'b1;
        in_ch.accel_x <= nx.accel_x; in_ch.accel_y <= nx.accel_y;
        in_ch.accel_z <= nx.accel_z; in_ch.pitch_angle <= nx.pitch_angle;
        in_ch.roll_angle <= nx.roll_angle; in_ch.lidar_height <= nx.lidar_height;
        in_ch.flow_dx <= nx.flow_dx; in_ch.flow_dy <= nx.flow_dy;
        if (burst_left > 0) begin
          burst_left <= burst_left - 1;
        end else begin
          burst_left <= $urandom_range(0, 8);
          gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 300);
        end
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // Receiver stall pattern: phases of always-ready alternate with random stalls.
  int stall_phase = 0;
  always @(negedge clk) begin
    stall_phase <= stall_phase + 1;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else if (stall_phase[11]) begin
      out_ch.ready <= 1'b1;
    end else begin
      out_ch.ready <= ($urandom_range(0, 3) != 0) || (stall_phase[3:0] == 4'hF);
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) begin
        nav_state_t e;
        dead_reckon(imu_sample_t'{in_ch.accel_x, in_ch.accel_y, in_ch.accel_z,
                    in_ch.pitch_angle, in_ch.roll_angle, in_ch.lidar_height,
                    in_ch.flow_dx, in_ch.flow_dy}, e);
        nav_expect_q.push_back(e);
        samples_sent++;
      end
      if (cfg_ch.valid && cfg_ch.ready) begin
        model_write(reg_write_t'{cfg_ch.idx, cfg_ch.data});
        regs_written++;
      end
      if (out_ch.valid && out_ch.ready) begin
        nav_state_t got, exp_r;
        got = '{out_ch.pos_x, out_ch.pos_y, out_ch.pos_z, out_ch.vel_x, out_ch.vel_y,
                out_ch.vel_z};
        results_seen++;
        if (nav_expect_q.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected result beat: %p", got);
        end else begin
          exp_r = nav_expect_q.pop_front();
          if (got !== exp_r) begin
            errors++;
            if (errors <= 10)
              $display("result %0d mismatch\n  exp %p\n  got %p", results_seen, exp_r, got);
          end
        end
      end
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
          (cfg_ch.valid && cfg_ch.ready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT && !timed_out) begin
        timed_out = 1;
        $display("watchdog: no beat for %0d cycles", IDLE_LIMIT);
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [23:0] val);
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.idx <= idx;
    cfg_ch.data <= val;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  function automatic logic signed [15:0] rand_field16();
    case ($urandom_range(0, 5))
      0: return 16'sh7FFF;
      1: return 16'sh8000;
      2: return 16'(signed'($urandom_range(0, 64)) - 32);
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic imu_sample_t rand_sample(logic signed [31:0] base_h);
    imu_sample_t s;
    if ($urandom_range(0, 4) == 0) begin
      s = imu_sample_t'(144'({$urandom, $urandom, $urandom, $urandom, $urandom}));
    end else begin
      // Mostly near-level flight with small motions and a slowly varying height.
      s.accel_x = 16'(signed'($urandom_range(0, 1024)) - 512);
      s.accel_y = 16'(signed'($urandom_range(0, 1024)) - 512);
      s.accel_z = 16'(signed'($urandom_range(0, 1024)) - 512) + 16'sd2511;
      s.pitch_angle = 16'(signed'($urandom_range(0, 4000)) - 2000);
      s.roll_angle = 16'(signed'($urandom_range(0, 4000)) - 2000);
      s.lidar_height = base_h + 32'(signed'($urandom_range(0, 8192)) - 4096);
      s.flow_dx = 16'(signed'($urandom_range(0, 40)) - 20);
      s.flow_dy = 16'(signed'($urandom_range(0, 40)) - 20);
      if ($urandom_range(0, 9) == 0) begin
        s.accel_x = rand_field16(); s.pitch_angle = rand_field16();
        s.roll_angle = rand_field16(); s.flow_dy = rand_field16();
      end
    end
    return s;
  endfunction

  task automatic drain();
    while (sample_q.size() != 0 || nav_expect_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic random_phase(int count);
    logic signed [31:0] h;
    h = 32'sd65536 * $urandom_range(0, 20);
    for (int i = 0; i < count; i++) begin
      sample_q.push_back(rand_sample(h));
      h = h + 32'(signed'($urandom_range(0, 2000)) - 1000);
    end
    drain();
  endtask

  logic signed [15:0] edge_vals[6] = '{16'sh7FFF, 16'sh8000, 16'sh0000, 16'sh3243,
                                        -16'sh3243, 16'sh0001};

  initial begin
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.accel_x = '0; in_ch.accel_y = '0; in_ch.accel_z = '0;
    in_ch.pitch_angle = '0; in_ch.roll_angle = '0; in_ch.lidar_height = '0;
    in_ch.flow_dx = '0; in_ch.flow_dy = '0;
    out_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0; cfg_ch.idx = '0; cfg_ch.data = '0;
    model_reset();
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed: defaults, first-sample seeding, extreme fields and angles past pi/2.
    sample_q.push_back('{16'sd0, 16'sd0, 16'sd2511, 16'sd0, 16'sd0, 32'sd65536, 16'sd0,
                         16'sd0});
    for (int i = 0; i < 6; i++)
      sample_q.push_back('{edge_vals[i], edge_vals[5 - i], edge_vals[i], edge_vals[i],
                           edge_vals[5 - i], (i % 2) ? 32'sh80000000 : 32'sh7FFFFFFF,
                           edge_vals[i], edge_vals[5 - i]});
    sample_q.push_back('{16'sh8000, 16'sh8000, 16'sh8000, 16'sh6487, -16'sh6487,
                         -32'sd1000000, 16'sh8000, 16'sh7FFF});
    sample_q.push_back('{16'sh7FFF, 16'sh7FFF, 16'sh7FFF, -16'sh6488, 16'sh6488, 32'sd0,
                         16'sh7FFF, 16'sh8000});
    drain();

    // Zero time step, extreme gain, weights and flow scale, and an unused register index.
    write_reg(REG_TIME_STEP, 24'd0);
    write_reg(REG_GRAVITY, 24'hFFFF);
    write_reg(REG_ACCEL_SMOOTHING, 24'd0);
    write_reg(REG_VERTICAL_BLEND, 24'hFFFF);
    write_reg(REG_HORIZONTAL_BLEND, 24'd0);
    write_reg(REG_FLOW_TO_METERS, 24'hFFFFFF);
    write_reg(3'd7, 24'h123456);
    for (int i = 0; i < 6; i++)
      sample_q.push_back('{edge_vals[i], edge_vals[i], edge_vals[i], edge_vals[i],
                           edge_vals[i], 32'(signed'(i) - 3) * 32'sd400000, edge_vals[i],
                           -edge_vals[i]});
    drain();

    write_reg(REG_TIME_STEP, 24'hFFFF);
    write_reg(REG_GRAVITY, 24'd0);
    write_reg(REG_ACCEL_SMOOTHING, 24'hFFFF);
    write_reg(REG_VERTICAL_BLEND, 24'd0);
    write_reg(REG_HORIZONTAL_BLEND, 24'hFFFF);
    write_reg(REG_FLOW_TO_METERS, 24'd0);
    random_phase(200);

    write_reg(REG_TIME_STEP, 24'd655);
    write_reg(REG_GRAVITY, 24'd2511);
    write_reg(REG_ACCEL_SMOOTHING, 24'd58982);
    write_reg(REG_VERTICAL_BLEND, 24'd64225);
    write_reg(REG_HORIZONTAL_BLEND, 24'd58982);
    write_reg(REG_FLOW_TO_METERS, 24'd65536);
    random_phase(300);

    for (int p = 0; p < 5; p++) begin
      write_reg(REG_TIME_STEP, 24'($urandom_range(0, 65535)));
      write_reg(REG_GRAVITY, 24'($urandom_range(0, 65535)));
      write_reg(REG_ACCEL_SMOOTHING, 24'($urandom_range(0, 65535)));
      write_reg(REG_VERTICAL_BLEND, 24'($urandom_range(0, 65535)));
      write_reg(REG_HORIZONTAL_BLEND, 24'($urandom_range(0, 65535)));
      write_reg(REG_FLOW_TO_METERS, 24'($urandom));
      random_phase(100);
    end

    $display("covered %0d samples, %0d results, %0d register writes", samples_sent,
             results_seen, regs_written);
    $display("settings included zero and full-scale dt, gain, weights and flow scale");
    if (errors == 0 && nav_expect_q.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("%0d mismatches", errors);
      $display("DONE: errors detected");
    end
    $finish;
  end
endmodule

[sim.f]
rtl/core/imudr_pkg.sv
rtl/core/imudr_in_if.sv
rtl/core/imudr_out_if.sv
rtl/core/imudr_cfg_if.sv
rtl/core/imu_flow_lidar_dead_reckoning_unit.sv
bench/imudr_tb_pkg.sv
bench/tb_imu_flow_lidar_dead_reckoning_unit.sv
